// ----- src/pdp_pkg.sv -----
package pdp_pkg;

	localparam int QUO_W   = 48;
	localparam int DIV_LAT = QUO_W + 2;
	localparam int CFG_AW  = 6;

	typedef enum logic [2:0] {
		REG_FOCAL_X   = 3'd0,
		REG_FOCAL_Y   = 3'd1,
		REG_PRINCIPAL = 3'd2,
		REG_K1        = 3'd3,
		REG_K2        = 3'd4,
		REG_K3        = 3'd5,
		REG_P1        = 3'd6,
		REG_P2        = 3'd7
	} pdp_reg_t;

	typedef struct packed {
		logic [31:0]      rx;
		logic [31:0]      ry;
		logic [QUO_W-1:0] qx;
		logic [QUO_W-1:0] qy;
		logic [31:0]      d;
		logic             nx;
		logic             ny;
	} pdp_div_t;

endpackage

// ----- src/pdp_delay.sv -----
module pdp_delay #(
	parameter int W     = 32,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	assign q = dly_s[DEPTH-1];

endmodule

// ----- src/pdp_mulq.sv -----
module pdp_mulq #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int SH = 16,
	parameter int OW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [OW-1:0] p,
	output logic                 ov
);

	localparam int AL = (AW + 1) / 2;
	localparam int AH = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;
	localparam int QW = PW - SH;

	logic [AW-1:0] ua;
	logic [BW-1:0] ub;
	logic [AL+BL-1:0] pll_s1;
	logic [AL+BH-1:0] plh_s1;
	logic [AH+BL-1:0] phl_s1;
	logic [AH+BH-1:0] phh_s1;
	logic             neg_s1;
	logic [PW-1:0]    sum;
	logic [QW-1:0]    q;
	logic [QW-1:0]    lim;
	logic [OW-1:0]    m;

	assign ua = a[AW-1] ? AW'(-a) : AW'(a);
	assign ub = b[BW-1] ? BW'(-b) : BW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= (AL+BL)'(ua[AL-1:0]) * (AL+BL)'(ub[BL-1:0]);
			plh_s1 <= (AL+BH)'(ua[AL-1:0]) * (AL+BH)'(ub[BW-1:BL]);
			phl_s1 <= (AH+BL)'(ua[AW-1:AL]) * (AH+BL)'(ub[BL-1:0]);
			phh_s1 <= (AH+BH)'(ua[AW-1:AL]) * (AH+BH)'(ub[BW-1:BL]);
			neg_s1 <= a[AW-1] ^ b[BW-1];
		end
	end

	always_comb begin
		sum = PW'(pll_s1) + (PW'(plh_s1) << BL) + (PW'(phl_s1) << AL)
			+ (PW'(phh_s1) << (AL + BL));
		q   = sum[PW-1:SH];
		lim = (QW'(1) << (OW - 1)) - QW'(!neg_s1);
		m   = (q > lim) ? OW'(lim) : OW'(q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p  <= neg_s1 ? -m : m;
			ov <= q > lim;
		end
	end

endmodule

// ----- src/pdp_div.sv -----
module pdp_div #(
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [31:0]   x,
	input  logic signed [31:0]   y,
	input  logic signed [31:0]   z,
	output logic signed [DW-1:0] xp,
	output logic signed [DW-1:0] yp,
	output logic                 ov
);

	localparam int QW = pdp_pkg::QUO_W;

	pdp_pkg::pdp_div_t st_s [QW+1];
	pdp_pkg::pdp_div_t st0;
	logic [31:0] ax, ay, az;
	logic        zero;
	logic [DW:0] fx, fy;

	function automatic pdp_pkg::pdp_div_t div_step(input pdp_pkg::pdp_div_t s);
		pdp_pkg::pdp_div_t n;
		logic [32:0] tx, ty;
		logic        gx, gy;
		n  = s;
		tx = {s.rx, s.qx[QW-1]};
		ty = {s.ry, s.qy[QW-1]};
		gx = tx >= {1'b0, s.d};
		gy = ty >= {1'b0, s.d};
		if (gx) begin
			tx = tx - {1'b0, s.d};
		end
		if (gy) begin
			ty = ty - {1'b0, s.d};
		end
		n.rx = tx[31:0];
		n.ry = ty[31:0];
		n.qx = {s.qx[QW-2:0], gx};
		n.qy = {s.qy[QW-2:0], gy};
		return n;
	endfunction

	function automatic logic [DW:0] sat_q(input logic [QW-1:0] q, input logic neg);
		logic [QW-1:0] lim;
		logic [DW-1:0] m;
		logic          o;
		lim = (QW'(1) << (DW - 1)) - QW'(!neg);
		o   = q > lim;
		m   = o ? DW'(lim) : DW'(q);
		return {o, neg ? -m : m};
	endfunction

	always_comb begin
		ax   = x[31] ? 32'(-x) : 32'(x);
		ay   = y[31] ? 32'(-y) : 32'(y);
		az   = z[31] ? 32'(-z) : 32'(z);
		zero = z == 32'sd0;
		st0.rx = '0;
		st0.ry = '0;
		st0.qx = zero ? QW'(ax) : QW'({ax, 16'h0000});
		st0.qy = zero ? QW'(ay) : QW'({ay, 16'h0000});
		st0.d  = zero ? 32'd1 : az;
		st0.nx = x[31] ^ z[31];
		st0.ny = y[31] ^ z[31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= st0;
			for (int i = 1; i <= QW; i++) begin
				st_s[i] <= div_step(st_s[i-1]);
			end
		end
	end

	assign fx = sat_q(st_s[QW].qx, st_s[QW].nx);
	assign fy = sat_q(st_s[QW].qy, st_s[QW].ny);

	always_ff @(posedge clk) begin
		if (en) begin
			xp <= fx[DW-1:0];
			yp <= fy[DW-1:0];
			ov <= fx[DW] | fy[DW];
		end
	end

endmodule

// ----- src/pinhole_distortion_projector.sv -----
// Pinhole projector with radial and tangential lens distortion.
// Input stream s_*: one camera-frame point per item, x, y, z in signed Q16.16.
// Output stream m_*: one pixel coordinate per item, u and v in signed Q16.16,
// with the overflow flag on m_tuser when any step saturated.
// Camera constants sit on the APB port; write them only while no item is in
// flight, writes take effect for the next item.
// Each item passes a restoring divider (one quotient bit per stage for both x
// and y), then registered multipliers and saturating adders in sequence.
// Throughput is one item per cycle. All stages advance together; when the
// receiver holds m_tready low with a result waiting, the whole pipeline and
// s_tready stall, and nothing is dropped or repeated.
// Reset clears all valid bits and loads focal lengths of 1.0 with every other
// constant at zero.
module pinhole_distortion_projector #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [95:0]               s_tdata,   // point_x, point_y, point_z
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [63:0]               m_tdata,   // pixel_u, pixel_v
	output logic                      m_tuser,   // overflow
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [pdp_pkg::CFG_AW-1:0] paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready
);

	localparam int DW  = DATA_WIDTH;
	localparam int WW  = (DW > 32) ? DW : 32;
	localparam int LAT = pdp_pkg::DIV_LAT + 18;
	localparam logic signed [WW:0] DMAX  = $signed((WW+1)'({(DW-1){1'b1}}));
	localparam logic signed [WW:0] DMIN  = -DMAX - (WW+1)'(1);
	localparam logic signed [WW:0] MAX32 = $signed((WW+1)'(31'h7FFF_FFFF));
	localparam logic signed [WW:0] MIN32 = -MAX32 - (WW+1)'(1);

	function automatic logic [DW:0] add_sat(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		logic           [DW-1:0] r;
		logic                    o;
		s = (DW+1)'(a) + (DW+1)'(b);
		o = s[DW] != s[DW-1];
		r = s[DW-1:0];
		if (o) begin
			r = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end
		return {o, r};
	endfunction

	function automatic logic [DW:0] sat_in(input logic signed [31:0] a);
		logic signed [WW:0] w;
		logic [DW-1:0]      r;
		logic               o;
		w = (WW+1)'(a);
		o = 1'b0;
		r = w[DW-1:0];
		if (w > DMAX) begin
			o = 1'b1;
			r = DMAX[DW-1:0];
		end else if (w < DMIN) begin
			o = 1'b1;
			r = DMIN[DW-1:0];
		end
		return {o, r};
	endfunction

	function automatic logic [32:0] clamp32(input logic signed [DW-1:0] a);
		logic signed [WW:0] w;
		logic [31:0]        r;
		logic               o;
		w = (WW+1)'(a);
		o = 1'b0;
		r = w[31:0];
		if (w > MAX32) begin
			o = 1'b1;
			r = MAX32[31:0];
		end else if (w < MIN32) begin
			o = 1'b1;
			r = MIN32[31:0];
		end
		return {o, r};
	endfunction

	// configuration
	logic [31:0] focal_x_q, focal_y_q, k1_q, k2_q, k3_q, p1_q, p2_q;
	logic [63:0] pp_q;
	pdp_pkg::pdp_reg_t wsel;

	assign pready = 1'b1;
	assign wsel   = pdp_pkg::pdp_reg_t'(paddr[pdp_pkg::CFG_AW-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= 32'h0001_0000;
			focal_y_q <= 32'h0001_0000;
			pp_q      <= '0;
			k1_q      <= '0;
			k2_q      <= '0;
			k3_q      <= '0;
			p1_q      <= '0;
			p2_q      <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (wsel)
				pdp_pkg::REG_FOCAL_X:   focal_x_q <= pwdata[31:0];
				pdp_pkg::REG_FOCAL_Y:   focal_y_q <= pwdata[31:0];
				pdp_pkg::REG_PRINCIPAL: pp_q      <= pwdata;
				pdp_pkg::REG_K1:        k1_q      <= pwdata[31:0];
				pdp_pkg::REG_K2:        k2_q      <= pwdata[31:0];
				pdp_pkg::REG_K3:        k3_q      <= pwdata[31:0];
				pdp_pkg::REG_P1:        p1_q      <= pwdata[31:0];
				pdp_pkg::REG_P2:        p2_q      <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (wsel)
			pdp_pkg::REG_FOCAL_X:   prdata = {32'h0, focal_x_q};
			pdp_pkg::REG_FOCAL_Y:   prdata = {32'h0, focal_y_q};
			pdp_pkg::REG_PRINCIPAL: prdata = pp_q;
			pdp_pkg::REG_K1:        prdata = {32'h0, k1_q};
			pdp_pkg::REG_K2:        prdata = {32'h0, k2_q};
			pdp_pkg::REG_K3:        prdata = {32'h0, k3_q};
			pdp_pkg::REG_P1:        prdata = {32'h0, p1_q};
			pdp_pkg::REG_P2:        prdata = {32'h0, p2_q};
			default:                prdata = '0;
		endcase
	end

	// flow control
	logic           en;
	logic [LAT:1]   vld_s;

	assign en       = !vld_s[LAT] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// normalize
	logic signed [DW-1:0] xp_s0, yp_s0;
	logic                 dov_s0;

	pdp_div #(.DW(DW)) u_div (
		.clk (clk),
		.en  (en),
		.x   ($signed(s_tdata[31:0])),
		.y   ($signed(s_tdata[63:32])),
		.z   ($signed(s_tdata[95:64])),
		.xp  (xp_s0),
		.yp  (yp_s0),
		.ov  (dov_s0)
	);

	// squares
	logic signed [DW-1:0] xx_s2, yy_s2, xy_s2;
	logic                 xx_ov_s2, yy_ov_s2, xy_ov_s2;

	pdp_mulq #(.AW(DW), .BW(DW), .SH(16), .OW(DW)) u_mxx (
		.clk(clk), .en(en), .a(xp_s0), .b(xp_s0), .p(xx_s2), .ov(xx_ov_s2));
	pdp_mulq #(.AW(DW), .BW(DW), .SH(16), .OW(DW)) u_myy (
		.clk(clk), .en(en), .a(yp_s0), .b(yp_s0), .p(yy_s2), .ov(yy_ov_s2));
	pdp_mulq #(.AW(DW), .BW(DW), .SH(16), .OW(DW)) u_mxy (
		.clk(clk), .en(en), .a(xp_s0), .b(yp_s0), .p(xy_s2), .ov(xy_ov_s2));

	logic [DW:0] r2_c, xx2_c, yy2_c, xy2_c;
	logic signed [DW-1:0] r2_s3, xx2_s3, yy2_s3, xy2_s3;
	logic                 ov_s3;

	assign r2_c  = add_sat(xx_s2, yy_s2);
	assign xx2_c = add_sat(xx_s2, xx_s2);
	assign yy2_c = add_sat(yy_s2, yy_s2);
	assign xy2_c = add_sat(xy_s2, xy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s3  <= r2_c[DW-1:0];
			xx2_s3 <= xx2_c[DW-1:0];
			yy2_s3 <= yy2_c[DW-1:0];
			xy2_s3 <= xy2_c[DW-1:0];
			ov_s3  <= r2_c[DW] | xx2_c[DW] | yy2_c[DW] | xy2_c[DW];
		end
	end

	logic [DW:0] tx_c, ty_c;
	logic signed [DW-1:0] tx_s4, ty_s4;
	logic                 ov_s4;

	assign tx_c = add_sat(r2_s3, xx2_s3);
	assign ty_c = add_sat(r2_s3, yy2_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4 <= tx_c[DW-1:0];
			ty_s4 <= ty_c[DW-1:0];
			ov_s4 <= tx_c[DW] | ty_c[DW];
		end
	end

	// powers of r and coefficient products
	logic signed [DW-1:0] r4_s5, fa_s5, bx_s5, by_s5, r2_s5;
	logic                 r4_ov_s5, fa_ov_s5, bx_ov_s5, by_ov_s5;

	pdp_mulq #(.AW(DW), .BW(DW), .SH(16), .OW(DW)) u_mr4 (
		.clk(clk), .en(en), .a(r2_s3), .b(r2_s3), .p(r4_s5), .ov(r4_ov_s5));
	pdp_mulq #(.AW(32), .BW(DW), .SH(28), .OW(DW)) u_mfa (
		.clk(clk), .en(en), .a($signed(k1_q)), .b(r2_s3), .p(fa_s5), .ov(fa_ov_s5));
	pdp_mulq #(.AW(32), .BW(DW), .SH(28), .OW(DW)) u_mbx (
		.clk(clk), .en(en), .a($signed(p1_q)), .b(xy2_s3), .p(bx_s5), .ov(bx_ov_s5));
	pdp_mulq #(.AW(32), .BW(DW), .SH(28), .OW(DW)) u_mby (
		.clk(clk), .en(en), .a($signed(p2_q)), .b(xy2_s3), .p(by_s5), .ov(by_ov_s5));
	pdp_delay #(.W(DW), .DEPTH(2)) u_dr2 (
		.clk(clk), .en(en), .d(r2_s3), .q(r2_s5));

	logic signed [DW-1:0] ax_s6, ay_s6;
	logic                 ax_ov_s6, ay_ov_s6;

	pdp_mulq #(.AW(32), .BW(DW), .SH(28), .OW(DW)) u_max (
		.clk(clk), .en(en), .a($signed(p2_q)), .b(tx_s4), .p(ax_s6), .ov(ax_ov_s6));
	pdp_mulq #(.AW(32), .BW(DW), .SH(28), .OW(DW)) u_may (
		.clk(clk), .en(en), .a($signed(p1_q)), .b(ty_s4), .p(ay_s6), .ov(ay_ov_s6));

	logic signed [DW-1:0] r6_s7, fb_s7, fa_s7;
	logic                 r6_ov_s7, fb_ov_s7;

	pdp_mulq #(.AW(DW), .BW(DW), .SH(16), .OW(DW)) u_mr6 (
		.clk(clk), .en(en), .a(r2_s5), .b(r4_s5), .p(r6_s7), .ov(r6_ov_s7));
	pdp_mulq #(.AW(32), .BW(DW), .SH(28), .OW(DW)) u_mfb (
		.clk(clk), .en(en), .a($signed(k2_q)), .b(r4_s5), .p(fb_s7), .ov(fb_ov_s7));
	pdp_delay #(.W(DW), .DEPTH(2)) u_dfa (
		.clk(clk), .en(en), .d(fa_s5), .q(fa_s7));

	// radial factor
	logic [DW:0] fab_c;
	logic signed [DW-1:0] fab_s8, fab_s9, fk3_s9;
	logic                 fab_ov_s8, fk3_ov_s9;

	assign fab_c = add_sat(fa_s7, fb_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			fab_s8    <= fab_c[DW-1:0];
			fab_ov_s8 <= fab_c[DW];
		end
	end

	pdp_mulq #(.AW(32), .BW(DW), .SH(28), .OW(DW)) u_mfk3 (
		.clk(clk), .en(en), .a($signed(k3_q)), .b(r6_s7), .p(fk3_s9), .ov(fk3_ov_s9));
	pdp_delay #(.W(DW), .DEPTH(1)) u_dfab (
		.clk(clk), .en(en), .d(fab_s8), .q(fab_s9));

	logic [DW:0] f_c;
	logic signed [DW-1:0] f_s10;
	logic                 f_ov_s10;

	assign f_c = add_sat(fab_s9, fk3_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			f_s10    <= f_c[DW-1:0];
			f_ov_s10 <= f_c[DW];
		end
	end

	// distorted coordinates
	logic [2*DW-1:0]      xy_s10, xy_s12;
	logic signed [DW-1:0] mx_s12, my_s12;
	logic                 mx_ov_s12, my_ov_s12;

	pdp_delay #(.W(2*DW), .DEPTH(10)) u_dxy10 (
		.clk(clk), .en(en), .d({yp_s0, xp_s0}), .q(xy_s10));
	pdp_delay #(.W(2*DW), .DEPTH(2)) u_dxy12 (
		.clk(clk), .en(en), .d(xy_s10), .q(xy_s12));
	pdp_mulq #(.AW(DW), .BW(DW), .SH(16), .OW(DW)) u_mmx (
		.clk(clk), .en(en), .a($signed(xy_s10[DW-1:0])), .b(f_s10),
		.p(mx_s12), .ov(mx_ov_s12));
	pdp_mulq #(.AW(DW), .BW(DW), .SH(16), .OW(DW)) u_mmy (
		.clk(clk), .en(en), .a($signed(xy_s10[2*DW-1:DW])), .b(f_s10),
		.p(my_s12), .ov(my_ov_s12));

	logic [DW:0] xa_c, ya_c, xb_c, yb_c, xc_c, yc_c;
	logic signed [DW-1:0] xpp_s13, ypp_s13, xpp_s14, ypp_s14, xpp_s15, ypp_s15;
	logic signed [DW-1:0] ax_s13, ay_s13, bx_s14, by_s14;
	logic                 ov_s13, ov_s14, ov_s15;

	assign xa_c = add_sat($signed(xy_s12[DW-1:0]), mx_s12);
	assign ya_c = add_sat($signed(xy_s12[2*DW-1:DW]), my_s12);

	pdp_delay #(.W(2*DW), .DEPTH(7)) u_da (
		.clk(clk), .en(en), .d({ay_s6, ax_s6}), .q({ay_s13, ax_s13}));
	pdp_delay #(.W(2*DW), .DEPTH(9)) u_db (
		.clk(clk), .en(en), .d({by_s5, bx_s5}), .q({by_s14, bx_s14}));

	assign xb_c = add_sat(xpp_s13, ax_s13);
	assign yb_c = add_sat(ypp_s13, ay_s13);
	assign xc_c = add_sat(xpp_s14, bx_s14);
	assign yc_c = add_sat(ypp_s14, by_s14);

	always_ff @(posedge clk) begin
		if (en) begin
			xpp_s13 <= xa_c[DW-1:0];
			ypp_s13 <= ya_c[DW-1:0];
			ov_s13  <= xa_c[DW] | ya_c[DW];
			xpp_s14 <= xb_c[DW-1:0];
			ypp_s14 <= yb_c[DW-1:0];
			ov_s14  <= xb_c[DW] | yb_c[DW];
			xpp_s15 <= xc_c[DW-1:0];
			ypp_s15 <= yc_c[DW-1:0];
			ov_s15  <= xc_c[DW] | yc_c[DW];
		end
	end

	// focal scale and principal point
	logic signed [DW-1:0] mu_s17, mv_s17;
	logic                 mu_ov_s17, mv_ov_s17;

	pdp_mulq #(.AW(33), .BW(DW), .SH(16), .OW(DW)) u_mmu (
		.clk(clk), .en(en), .a($signed({1'b0, focal_x_q})), .b(xpp_s15),
		.p(mu_s17), .ov(mu_ov_s17));
	pdp_mulq #(.AW(33), .BW(DW), .SH(16), .OW(DW)) u_mmv (
		.clk(clk), .en(en), .a($signed({1'b0, focal_y_q})), .b(ypp_s15),
		.p(mv_s17), .ov(mv_ov_s17));

	logic [DW:0] cx_c, cy_c, su_c, sv_c;
	logic [32:0] cu_c, cv_c;

	assign cx_c = sat_in($signed(pp_q[63:32]));
	assign cy_c = sat_in($signed(pp_q[31:0]));
	assign su_c = add_sat(mu_s17, $signed(cx_c[DW-1:0]));
	assign sv_c = add_sat(mv_s17, $signed(cy_c[DW-1:0]));
	assign cu_c = clamp32($signed(su_c[DW-1:0]));
	assign cv_c = clamp32($signed(sv_c[DW-1:0]));

	// overflow gathering
	logic [17:0] fl;
	logic [17:1] ov_s;
	logic [31:0] u_s18, v_s18;
	logic        ov_s18;

	always_comb begin
		fl     = '0;
		fl[0]  = dov_s0;
		fl[2]  = xx_ov_s2 | yy_ov_s2 | xy_ov_s2;
		fl[3]  = ov_s3;
		fl[4]  = ov_s4;
		fl[5]  = r4_ov_s5 | fa_ov_s5 | bx_ov_s5 | by_ov_s5;
		fl[6]  = ax_ov_s6 | ay_ov_s6;
		fl[7]  = r6_ov_s7 | fb_ov_s7;
		fl[8]  = fab_ov_s8;
		fl[9]  = fk3_ov_s9;
		fl[10] = f_ov_s10;
		fl[12] = mx_ov_s12 | my_ov_s12;
		fl[13] = ov_s13;
		fl[14] = ov_s14;
		fl[15] = ov_s15;
		fl[17] = mu_ov_s17 | mv_ov_s17;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ov_s[1] <= fl[0];
			for (int k = 2; k <= 17; k++) begin
				ov_s[k] <= ov_s[k-1] | fl[k-1];
			end
			u_s18  <= cu_c[31:0];
			v_s18  <= cv_c[31:0];
			ov_s18 <= ov_s[17] | fl[17] | cx_c[DW] | cy_c[DW] | su_c[DW] | sv_c[DW]
				| cu_c[32] | cv_c[32];
		end
	end

	assign m_tdata = {v_s18, u_s18};
	assign m_tuser = ov_s18;

endmodule
